/* hw/rtl/rrts_pkg.sv */
// Shared types, constants and helpers for the round-robin thread scheduler.
// No dependencies; imported by every module of the block except the RAM.
package rrts_pkg;

  localparam int NUM_CPUS    = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  // Port field widths, fixed by the stream format.
  localparam int FUNC_W   = 3;
  localparam int CPU_IN_W = 2;
  localparam int ID_IN_W  = 8;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 5;

  localparam int QADDR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CPU_CMP_W = 7;
  localparam int ENTRY_W = 2 * ID_BITS;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_ENQ    = 3'd1,
    FN_REMOVE = 3'd2,
    FN_EXIT   = 3'd3,
    FN_READY  = 3'd4
  } func_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_SWITCH = 2'd1,
    ACT_IDLE   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SWITCH,
    ST_POP,
    ST_DONE
  } state_t;

  // Queue entry: thread in the low half, process in the high half.
  typedef struct packed {
    logic [ID_BITS-1:0] proc;
    logic [ID_BITS-1:0] thr;
  } entry_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CPU_IN_W-1:0] cpu;
    logic [ID_IN_W-1:0]  thr;
    logic [ID_IN_W-1:0]  proc;
    logic                user;
  } item_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_IN_W-1:0]  run_thread;
    logic [ID_IN_W-1:0]  run_process;
    logic                dropped;
    logic [COUNT_W-1:0]  queue_count;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

  // Physical slot of logical position i counted from head, with wrap.
  function automatic logic [QADDR_W-1:0] q_slot(input logic [QADDR_W-1:0] h,
                                                input logic [FILL_W-1:0]  i);
    logic [FILL_W:0] s;
    s = (FILL_W + 1)'(h) + (FILL_W + 1)'(i);
    if (s >= (FILL_W + 1)'(QUEUE_DEPTH)) s = s - (FILL_W + 1)'(QUEUE_DEPTH);
    return QADDR_W'(s);
  endfunction

endpackage

/* hw/rtl/rrts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rrts_engine.sv */
// Scheduler sequencer: queue pointers, per-CPU tables and the scan/compare unit.
// Depends on rrts_pkg and rrts_ram (the ready queue storage).
module rrts_engine
  import rrts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  item_t     in_item,
  input  logic      out_free,
  output eng_stat_t stat,
  output result_t   result
);

  state_t state, state_next;
  item_t  item;

  logic [QADDR_W-1:0] head, head_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic [FILL_W-1:0]  scan_i, scan_i_next;
  logic [FILL_W-1:0]  kept, kept_next;
  logic [ID_BITS-1:0] scan_key, scan_key_next;
  logic               scan_by_proc, scan_by_proc_next;

  action_t            res_action, res_action_next;
  entry_t             res_run, res_run_next;
  logic               res_dropped, res_dropped_next;

  entry_t             cur [NUM_CPUS];
  logic [NUM_CPUS-1:0] cur_valid;
  logic [NUM_CPUS-1:0] cpu_ready;

  logic               cur_we, valid_we, valid_wval, ready_we;

  logic               ram_we;
  logic [QADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  logic [CPU_W-1:0]   cidx;
  logic               cpu_ok;
  entry_t             in_entry;
  entry_t             cur_sel;
  logic [ID_BITS-1:0] scan_field;

  assign cidx     = CPU_W'(item.cpu);
  assign cpu_ok   = CPU_CMP_W'(item.cpu) < CPU_CMP_W'(NUM_CPUS);
  assign in_entry = '{proc: ID_BITS'(item.proc), thr: ID_BITS'(item.thr)};
  assign cur_sel  = cur[cidx];
  assign scan_field = scan_by_proc ? ram_rdata.proc : ram_rdata.thr;

  rrts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (item.func)
          FN_TICK:   state_next = cpu_ok ? ST_SWITCH : ST_DONE;
          FN_REMOVE: state_next = ST_SCAN_RD;
          FN_EXIT: begin
            if (cpu_ok && item.user) begin
              state_next = cur_valid[cidx] ? ST_SCAN_RD : ST_SWITCH;
            end else begin
              state_next = ST_DONE;
            end
          end
          default:   state_next = ST_DONE;
        endcase
      end
      ST_SCAN_RD: begin
        if (scan_i < fill) begin
          state_next = ST_SCAN_CHK;
        end else begin
          state_next = (item.func == FN_EXIT) ? ST_SWITCH : ST_DONE;
        end
      end
      ST_SCAN_CHK: state_next = ST_SCAN_RD;
      ST_SWITCH: begin
        state_next = (cpu_ready[cidx] && fill != '0) ? ST_POP : ST_DONE;
      end
      ST_POP:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    head_next         = head;
    fill_next         = fill;
    scan_i_next       = scan_i;
    kept_next         = kept;
    scan_key_next     = scan_key;
    scan_by_proc_next = scan_by_proc;
    res_action_next   = res_action;
    res_run_next      = res_run;
    res_dropped_next  = res_dropped;
    cur_we            = 1'b0;
    valid_we          = 1'b0;
    valid_wval        = 1'b0;
    ready_we          = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = in_entry;
    ram_raddr         = head;
    case (state)
      ST_DISPATCH: begin
        res_action_next  = ACT_NONE;
        res_run_next     = '0;
        res_dropped_next = 1'b0;
        scan_i_next      = '0;
        kept_next        = '0;
        case (item.func)
          FN_ENQ: begin
            if (fill >= FILL_W'(QUEUE_DEPTH)) begin
              res_dropped_next = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = q_slot(head, fill);
              fill_next = fill + 1'b1;
            end
          end
          FN_REMOVE: begin
            scan_key_next     = ID_BITS'(item.thr);
            scan_by_proc_next = 1'b0;
          end
          FN_EXIT: begin
            if (cpu_ok && item.user && cur_valid[cidx]) begin
              valid_we          = 1'b1;
              valid_wval        = 1'b0;
              scan_key_next     = cur_sel.proc;
              scan_by_proc_next = 1'b1;
            end
          end
          FN_READY: ready_we = cpu_ok;
          default: ;
        endcase
      end
      ST_SCAN_RD: begin
        ram_raddr = q_slot(head, scan_i);
        if (!(scan_i < fill)) fill_next = kept;
      end
      ST_SCAN_CHK: begin
        if (scan_field != scan_key) begin
          ram_we    = 1'b1;
          ram_waddr = q_slot(head, kept);
          ram_wdata = ram_rdata;
          kept_next = kept + 1'b1;
        end
        scan_i_next = scan_i + 1'b1;
      end
      ST_SWITCH: begin
        ram_raddr = head;
        if (!(cpu_ready[cidx] && fill != '0) && item.func == FN_EXIT) begin
          res_action_next = ACT_IDLE;
        end
      end
      ST_POP: begin
        // Pop the head; the old current thread (if any) lands at the new tail.
        head_next = q_slot(head, FILL_W'(1));
        if (cur_valid[cidx]) begin
          ram_we    = 1'b1;
          ram_waddr = q_slot(head, fill);
          ram_wdata = cur_sel;
        end else begin
          fill_next = fill - 1'b1;
        end
        cur_we          = 1'b1;
        valid_we        = 1'b1;
        valid_wval      = 1'b1;
        res_action_next = ACT_SWITCH;
        res_run_next    = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      cur_valid <= '0;
      cpu_ready <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      if (valid_we) cur_valid[cidx] <= valid_wval;
      if (ready_we) cpu_ready[cidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == ST_IDLE) item <= in_item;
    if (cur_we) cur[cidx] <= ram_rdata;
    scan_i       <= scan_i_next;
    kept         <= kept_next;
    scan_key     <= scan_key_next;
    scan_by_proc <= scan_by_proc_next;
    res_action   <= res_action_next;
    res_run      <= res_run_next;
    res_dropped  <= res_dropped_next;
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE) && out_free;

  assign result.action      = res_action;
  assign result.run_thread  = ID_IN_W'(res_run.thr);
  assign result.run_process = ID_IN_W'(res_run.proc);
  assign result.dropped     = res_dropped;
  assign result.queue_count = COUNT_W'(fill);

endmodule

/* hw/rtl/round_robin_thread_scheduler.sv */
// Round-robin thread scheduler, top level: stream ports and result register.
// Depends on rrts_pkg and rrts_engine (which holds rrts_ram).
//
// A ready queue of (thread, process) entries shared by four CPUs, each with a
// current thread and a ready flag. Each input beat is one event (s_tuser):
// timer tick, enqueue, remove a thread, exit of the current thread, or mark a
// CPU ready; each event yields exactly one output beat with the action taken
// on the CPU, the thread it now runs, a drop flag for a refused enqueue, and
// the queue fill after the event. One event is in flight at a time; s_tready
// is low while it works and during reset. Enqueue, ready and ignored events
// go from dispatch straight to the result; a tick passes a switch check and,
// when it switches, a pop, and a user-mode exit with no current thread takes
// the same path. A thread removal sweeps the queue through the single-read
// queue RAM, with a read state and a check state per queued entry; a user-mode
// exit with a current thread sweeps the same way and then switches.
// The result sits in an output register, so the next event is taken while a
// result still waits for m_tready; a finished event only stalls if the prior
// result has not yet been taken. No clearing pass is needed after reset.
module round_robin_thread_scheduler
  import rrts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [1:0] cpu_id, [9:2] thread_id, [17:10] process_id, [18] user_mode, rest 0
  input  logic [23:0]         s_tdata,
  // [2:0] func
  input  logic [FUNC_W-1:0]   s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [7:0] run_thread, [15:8] run_process, [16] dropped, [21:17] queue_count
  output logic [23:0]         m_tdata,
  // [1:0] action
  output logic [ACTION_W-1:0] m_tuser
);

  item_t     in_item;
  eng_stat_t stat;
  result_t   eng_res;
  result_t   out_res;
  logic      start;
  logic      out_free;

  assign in_item.func = s_tuser;
  assign in_item.cpu  = s_tdata[1:0];
  assign in_item.thr  = s_tdata[9:2];
  assign in_item.proc = s_tdata[17:10];
  assign in_item.user = s_tdata[18];

  // No beat is taken while reset is held.
  assign s_tready = stat.idle && !rst;
  assign start    = s_tvalid && s_tready;
  // Output register may be reloaded when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  rrts_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_item  (in_item),
    .out_free (out_free),
    .stat     (stat),
    .result   (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) out_res <= eng_res;
  end

  assign m_tuser = out_res.action;
  assign m_tdata = {2'b00, out_res.queue_count, out_res.dropped,
                    out_res.run_process, out_res.run_thread};

`ifndef SYNTHESIS
  // A result is never produced over one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (!m_tvalid || m_tready))
    else $error("result produced while output register is full");

  // One event at a time: after an accept the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready)
    else $error("input accepted while an event is in flight");

  // Reported fill never exceeds the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:17] <= COUNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  // Run fields are zero unless the CPU switched.
  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ACT_SWITCH) |-> (m_tdata[15:0] == '0))
    else $error("run fields set without a switch");
`endif

endmodule
